FILE: sv/sts_pkg.sv
// Package for the sorted table search core: table geometry, field widths,
// operation codes and sequencer states. No dependencies.
package sts_pkg;

   localparam int DEPTH      = 1024;
   localparam int DATA_WIDTH = 32;
   localparam int ADDR_W     = $clog2(DEPTH);
   localparam int CNT_W      = $clog2(DEPTH + 1);
   localparam int VALUE_W    = 32;
   localparam int OP_W       = 2;
   localparam int POS_W      = 10;
   localparam int RSP_DATA_W = 16;

   typedef logic [OP_W-1:0] op_type;

   localparam op_type OP_CLEAR  = 2'd0;
   localparam op_type OP_APPEND = 2'd1;
   localparam op_type OP_SEARCH = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_CMP,
      ST_DONE
   } state_type;

endpackage

FILE: sv/sts_ram.sv
// Generic single-port RAM with registered read data.
// Standalone; used for the value table of the search core.
module sts_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data_ff <= mem[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/sorted_table_binary_search_core.sv
// Top level of the sorted table search core: sequencer, bounds registers
// and result register. Depends on sts_pkg and sts_ram.

// The core keeps a table of up to DEPTH signed values that software appends
// in ascending order; tuser selects clear, append or search and tdata carries
// the value or key. Clear and append return nothing; an append to a full
// table is dropped. A search returns one transaction with found in rsp_tuser
// and the matching index in rsp_tdata (index 0 on a miss, and always a miss
// on an empty table). A search makes at most log2(DEPTH)+1 probes; a search
// on an empty table skips the probes. Each probe is one read of the single
// table RAM port followed by one signed compare that also forms the next
// probe address. The core takes no new transaction while a search runs.
// Entries that were never appended are never read, so the table needs no
// initialization after reset.
module sorted_table_binary_search_core
   import sts_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [VALUE_W-1:0]    req_tdata,   // [31:0] value
   input  logic [OP_W-1:0]       req_tuser,   // [1:0] opcode
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [9:0] position, rest zero
   output logic                  rsp_tuser    // [0] found
);

   state_type state_ff, state_in;

   logic [CNT_W-1:0]      count_ff, count_in;
   logic [ADDR_W-1:0]     low_ff, low_in;
   logic [ADDR_W-1:0]     high_ff, high_in;
   logic [ADDR_W-1:0]     mid_ff, mid_in;
   logic [DATA_WIDTH-1:0] key_ff, key_in;
   logic                  res_found_ff, res_found_in;
   logic [POS_W-1:0]      res_pos_ff, res_pos_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_found_ff, rsp_found_in;
   logic [POS_W-1:0]      rsp_pos_ff, rsp_pos_in;

   logic                  ram_wr_en;
   logic [ADDR_W-1:0]     ram_addr;
   logic [DATA_WIDTH-1:0] ram_wr_data;
   logic [DATA_WIDTH-1:0] ram_rd_data;

   logic                  req_fire;
   logic                  out_free;
   logic                  hit;
   logic                  below;
   logic                  last_probe;
   logic [DATA_WIDTH-1:0] req_value;

   assign req_fire  = req_tvalid && req_tready;
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign req_value = DATA_WIDTH'($signed(req_tdata));
   assign hit       = ($signed(ram_rd_data) == $signed(key_ff));
   assign below     = ($signed(ram_rd_data) <  $signed(key_ff));
   assign last_probe = below ? (mid_ff == high_ff) : (mid_ff == low_ff);

   sts_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .addr    (ram_addr),
      .wr_data (ram_wr_data),
      .rd_data (ram_rd_data)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && req_tuser == OP_SEARCH) begin
               state_in = (count_ff == '0) ? ST_DONE : ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (hit || last_probe) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Datapath and outputs
   always_comb begin
      req_tready   = (state_ff == ST_IDLE);
      count_in     = count_ff;
      low_in       = low_ff;
      high_in      = high_ff;
      key_in       = key_ff;
      res_found_in = res_found_ff;
      res_pos_in   = res_pos_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_found_in = rsp_found_ff;
      rsp_pos_in   = rsp_pos_ff;
      ram_wr_en    = 1'b0;
      ram_wr_data  = req_value;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_tuser)
                  OP_CLEAR: begin
                     count_in = '0;
                  end
                  OP_APPEND: begin
                     if (count_ff < CNT_W'(DEPTH)) begin
                        ram_wr_en = 1'b1;
                        count_in  = count_ff + 1'b1;
                     end
                  end
                  OP_SEARCH: begin
                     key_in       = req_value;
                     low_in       = '0;
                     high_in      = ADDR_W'(count_ff - 1'b1);
                     res_found_in = 1'b0;
                     res_pos_in   = '0;
                  end
                  default: begin
                     // undefined opcode: drop the transaction
                  end
               endcase
            end
         end
         ST_CMP: begin
            if (hit) begin
               res_found_in = 1'b1;
               res_pos_in   = POS_W'(mid_ff);
            end else if (!last_probe) begin
               if (below) begin
                  low_in = mid_ff + 1'b1;
               end else begin
                  high_in = mid_ff - 1'b1;
               end
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = res_found_ff;
               rsp_pos_in   = res_pos_ff;
            end
         end
         default: begin
         end
      endcase
      // Probe address follows the updated bounds; appends write at the fill count.
      mid_in   = low_in + ((high_in - low_in) >> 1);
      ram_addr = ram_wr_en ? ADDR_W'(count_ff) : mid_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      low_ff       <= low_in;
      high_ff      <= high_in;
      mid_ff       <= mid_in;
      key_ff       <= key_in;
      res_found_ff <= res_found_in;
      res_pos_ff   <= res_pos_in;
      rsp_found_ff <= rsp_found_in;
      rsp_pos_ff   <= rsp_pos_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(rsp_pos_ff);
   assign rsp_tuser  = rsp_found_ff;

endmodule
